/* src/rsms_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rsms_pkg
// Shared types and codes for the reverse spiral matrix scan block.
// ============================================================================
package rsms_pkg;

    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

    // Command codes.
    localparam logic CMD_READ = 1'b1;

    // Result status codes.
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_NOT_READY = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [VALUE_W-1:0] elem_value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      is_last;
        logic                      status;
    } t_out;

    // Classified request held in the queue between front and back.
    typedef struct packed {
        logic                      is_read;
        logic signed [VALUE_W-1:0] value;
    } t_req;

endpackage

/* src/rsms_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// rsms_front
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ============================================================================
module rsms_front import rsms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_in,
    output logic o_busy,
    output logic o_req_valid,
    output t_req o_req,
    input  logic i_pop
);

    localparam int DEPTH = 2;

    t_req       r_q [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    t_req       w_entry;

    assign o_busy      = (r_cnt == 2'(DEPTH));
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_start && !o_busy;

    always_comb begin
        w_entry.is_read = (i_in.cmd == CMD_READ);
        w_entry.value   = i_in.elem_value;
        n_cnt           = r_cnt + 2'(w_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_entry;
        end
    end

endmodule

/* src/rsms_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// rsms_back
// Executes queued requests: stores elements, walks the spiral into an order
// memory once the matrix is full, and returns elements in reverse order.
// ============================================================================
module rsms_back import rsms_pkg::*; #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  t_req                  i_req,
    output logic                  o_pop,
    input  logic [CFG_DATA_W-1:0] i_num_rows,
    input  logic [CFG_DATA_W-1:0] i_num_cols,
    output logic                  o_valid,
    output t_out                  o_out
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = AW + 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DRW   = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(MAX_COLS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_RD1  = 2'd2;
    localparam logic [1:0] S_RD2  = 2'd3;

    localparam logic [1:0] DIR_R = 2'd0;
    localparam logic [1:0] DIR_D = 2'd1;
    localparam logic [1:0] DIR_L = 2'd2;
    localparam logic [1:0] DIR_U = 2'd3;

    logic signed [VALUE_W-1:0] r_mat_mem [CELLS];
    logic [AW-1:0]             r_ord_mem [CELLS];
    logic signed [VALUE_W-1:0] r_mat_q;
    logic [AW-1:0]             r_ord_q;

    logic [1:0]     r_state, n_state;
    logic           r_full, n_full;
    logic [CW-1:0]  r_ld_cnt, n_ld_cnt;
    logic [CW-1:0]  r_rd_cnt, n_rd_cnt;
    logic [CW-1:0]  r_len, n_len;
    logic [DCW-1:0] r_cols_l, n_cols_l;
    logic [RW-1:0]  r_wrow, n_wrow;
    logic [CLW-1:0] r_wcol, n_wcol;
    logic [RW-1:0]  r_top, n_top;
    logic [RW-1:0]  r_bot, n_bot;
    logic [CLW-1:0] r_left, n_left;
    logic [CLW-1:0] r_right, n_right;
    logic [1:0]     r_dir, n_dir;
    logic [AW-1:0]  r_wn, n_wn;
    logic           r_valid, n_valid;
    t_out           r_out, n_out;

    logic [DRW-1:0] w_rows;
    logic [DCW-1:0] w_cols;
    logic [CW-1:0]  w_total;
    logic [CW-1:0]  w_ld_next;
    logic [CW-1:0]  w_rd_next;
    logic [CW-1:0]  w_pos;
    logic [CW-1:0]  w_lin;
    logic           w_mat_we, w_mat_re, w_ord_we, w_ord_re, w_walk_go;

    // Out-of-range sizes: zero counts as one, anything above the maximum as the maximum.
    always_comb begin
        if (i_num_rows == '0) begin
            w_rows = DRW'(1);
        end else if (32'(i_num_rows) > MAX_ROWS) begin
            w_rows = DRW'(MAX_ROWS);
        end else begin
            w_rows = DRW'(i_num_rows);
        end
        if (i_num_cols == '0) begin
            w_cols = DCW'(1);
        end else if (32'(i_num_cols) > MAX_COLS) begin
            w_cols = DCW'(MAX_COLS);
        end else begin
            w_cols = DCW'(i_num_cols);
        end
    end

    assign w_total   = CW'(w_rows) * CW'(w_cols);
    assign w_ld_next = r_ld_cnt + CW'(1);
    assign w_rd_next = r_rd_cnt + CW'(1);
    assign w_pos     = r_len - CW'(1) - r_rd_cnt;
    assign w_lin     = CW'(r_wrow) * CW'(r_cols_l) + CW'(r_wcol);

    always_comb begin
        n_state   = r_state;
        n_full    = r_full;
        n_ld_cnt  = r_ld_cnt;
        n_rd_cnt  = r_rd_cnt;
        n_len     = r_len;
        n_cols_l  = r_cols_l;
        n_wrow    = r_wrow;
        n_wcol    = r_wcol;
        n_top     = r_top;
        n_bot     = r_bot;
        n_left    = r_left;
        n_right   = r_right;
        n_dir     = r_dir;
        n_wn      = r_wn;
        n_valid   = 1'b0;
        n_out     = r_out;
        o_pop     = 1'b0;
        w_mat_we  = 1'b0;
        w_mat_re  = 1'b0;
        w_ord_we  = 1'b0;
        w_ord_re  = 1'b0;
        w_walk_go = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    // A size change may already have made the matrix full;
                    // walk first and take the request afterwards.
                    if (!r_full && r_ld_cnt >= w_total) begin
                        w_walk_go = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                        if (i_req.is_read) begin
                            if (!r_full) begin
                                n_valid         = 1'b1;
                                n_out.out_value = '0;
                                n_out.is_last   = 1'b0;
                                n_out.status    = ST_NOT_READY;
                            end else begin
                                w_ord_re = 1'b1;
                                n_state  = S_RD1;
                            end
                        end else if (!r_full) begin
                            w_mat_we = 1'b1;
                            n_ld_cnt = w_ld_next;
                            if (w_ld_next >= w_total) begin
                                w_walk_go = 1'b1;
                            end
                        end
                    end
                end
            end
            S_WALK: begin
                w_ord_we = 1'b1;
                n_wn     = r_wn + AW'(1);
                unique case (r_dir)
                    DIR_R: begin
                        if (r_wcol < r_right) begin
                            n_wcol = r_wcol + CLW'(1);
                        end else begin
                            n_top  = r_top + RW'(1);
                            n_dir  = DIR_D;
                            n_wrow = r_wrow + RW'(1);
                        end
                    end
                    DIR_D: begin
                        if (r_wrow < r_bot) begin
                            n_wrow = r_wrow + RW'(1);
                        end else begin
                            n_right = r_right - CLW'(1);
                            n_dir   = DIR_L;
                            n_wcol  = r_wcol - CLW'(1);
                        end
                    end
                    DIR_L: begin
                        if (r_wcol > r_left) begin
                            n_wcol = r_wcol - CLW'(1);
                        end else begin
                            n_bot  = r_bot - RW'(1);
                            n_dir  = DIR_U;
                            n_wrow = r_wrow - RW'(1);
                        end
                    end
                    DIR_U: begin
                        if (r_wrow > r_top) begin
                            n_wrow = r_wrow - RW'(1);
                        end else begin
                            n_left = r_left + CLW'(1);
                            n_dir  = DIR_R;
                            n_wcol = r_wcol + CLW'(1);
                        end
                    end
                endcase
                if (CW'(r_wn) == r_len - CW'(1)) begin
                    n_full  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD1: begin
                w_mat_re = 1'b1;
                n_state  = S_RD2;
            end
            S_RD2: begin
                n_valid         = 1'b1;
                n_out.out_value = r_mat_q;
                n_out.status    = ST_OK;
                n_state         = S_IDLE;
                if (w_rd_next >= r_len) begin
                    n_out.is_last = 1'b1;
                    n_ld_cnt      = '0;
                    n_rd_cnt      = '0;
                    n_full        = 1'b0;
                end else begin
                    n_out.is_last = 1'b0;
                    n_rd_cnt      = w_rd_next;
                end
            end
        endcase

        if (w_walk_go) begin
            n_state  = S_WALK;
            n_len    = w_total;
            n_cols_l = w_cols;
            n_top    = '0;
            n_bot    = RW'(w_rows - DRW'(1));
            n_left   = '0;
            n_right  = CLW'(w_cols - DCW'(1));
            n_wrow   = '0;
            n_wcol   = '0;
            n_dir    = DIR_R;
            n_wn     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_full   <= 1'b0;
            r_ld_cnt <= '0;
            r_rd_cnt <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_full   <= n_full;
            r_ld_cnt <= n_ld_cnt;
            r_rd_cnt <= n_rd_cnt;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_cols_l <= n_cols_l;
        r_wrow   <= n_wrow;
        r_wcol   <= n_wcol;
        r_top    <= n_top;
        r_bot    <= n_bot;
        r_left   <= n_left;
        r_right  <= n_right;
        r_dir    <= n_dir;
        r_wn     <= n_wn;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_mat_we) begin
            r_mat_mem[r_ld_cnt[AW-1:0]] <= i_req.value;
        end
        if (w_mat_re) begin
            r_mat_q <= r_mat_mem[r_ord_q];
        end
        if (w_ord_we) begin
            r_ord_mem[r_wn] <= w_lin[AW-1:0];
        end
        if (w_ord_re) begin
            r_ord_q <= r_ord_mem[w_pos[AW-1:0]];
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

/* src/reverse_spiral_matrix_scan_top.sv */
`timescale 1ns / 1ps
// Order: a load is queued on acceptance and stored when the back end pops it; a read is
// registered out after the order memory read, S_RD1 and S_RD2, a not-ready result on pop.
// Throughput: one load per cycle while not busy and no walk runs; a read holds the back end
// until its result is out, set by the two chained memory reads (order memory, then element
// memory). The load that fills the matrix adds a spiral walk, one order write per cycle.
// Reset: synchronous, active low; empties the queue and the matrix, sizes return to 1x1.
// ============================================================================
// reverse_spiral_matrix_scan_top
// Loads a matrix row-major and returns its elements in reverse spiral order.
// ============================================================================
module reverse_spiral_matrix_scan_top import rsms_pkg::*; #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_in                   i_in,
    output logic                  busy,
    output logic                  o_valid,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_num_rows;
    logic [CFG_DATA_W-1:0] r_num_cols;
    logic                  w_req_valid;
    t_req                  w_req;
    logic                  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_DATA_W'(1);
            r_num_cols <= CFG_DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                REG_NUM_COLS: r_num_cols <= i_cfg_data;
            endcase
        end
    end

    rsms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_in        (i_in),
        .o_busy      (busy),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_pop       (w_pop)
    );

    rsms_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_pop       (w_pop),
        .i_num_rows  (r_num_rows),
        .i_num_cols  (r_num_cols),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    // The back end only takes requests that the queue actually holds.
    a_pop_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_req_valid)
        else $error("request popped from an empty queue");

    a_not_ready_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == ST_NOT_READY) |-> (o_out.out_value == '0 && !o_out.is_last))
        else $error("not-ready result carries data or a last flag");

    a_last_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.is_last) |-> (o_out.status == ST_OK))
        else $error("last flag on a result that is not valid data");

endmodule
